[sv/eptt_pkg.sv]
// Types, constants and fixed-point helpers for the Euler pose to transform core.
// Used by every module of the block; no dependencies.
package eptt_pkg;

  localparam int CordicSteps = 16;
  localparam int StepW       = 4;
  localparam int LaneW       = 34;   // Q2.30 working width with guard bits
  localparam int TrigW       = 32;   // Q2.30 sine and cosine after the chain
  localparam int AngleW      = 16;
  localparam int ShiftW      = 32;
  localparam int EntryW      = 16;
  localparam int Latency     = 20;   // fold + 16 cells + 3 matrix stages

  localparam logic signed [LaneW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [17:0]      QuarterTurn = 18'sd16384;
  localparam logic signed [17:0]      HalfTurn    = 18'sd32768;
  localparam logic signed [17:0]      Q14One      = 18'sd16384;

  localparam int LROLL  = 0;
  localparam int LPITCH = 1;
  localparam int LYAW   = 2;

  typedef struct packed {
    logic signed [AngleW-1:0] roll_angle;
    logic signed [AngleW-1:0] pitch_angle;
    logic signed [AngleW-1:0] yaw_angle;
    logic signed [ShiftW-1:0] shift_x;
    logic signed [ShiftW-1:0] shift_y;
    logic signed [ShiftW-1:0] shift_z;
  } pose_req_t;

  typedef struct packed {
    logic signed [EntryW-1:0] r00;
    logic signed [EntryW-1:0] r01;
    logic signed [EntryW-1:0] r02;
    logic signed [EntryW-1:0] r10;
    logic signed [EntryW-1:0] r11;
    logic signed [EntryW-1:0] r12;
    logic signed [EntryW-1:0] r20;
    logic signed [EntryW-1:0] r21;
    logic signed [EntryW-1:0] r22;
    logic signed [ShiftW-1:0] out_x;
    logic signed [ShiftW-1:0] out_y;
    logic signed [ShiftW-1:0] out_z;
  } xform_res_t;

  typedef struct packed {
    logic signed [LaneW-1:0] x;
    logic signed [LaneW-1:0] y;
    logic signed [LaneW-1:0] z;
    logic                    flip;
  } cordic_lane_t;

  // one slot of the cell chain: three angle lanes plus the translation tag
  typedef struct packed {
    logic                    valid;
    cordic_lane_t [2:0]      lane;
    logic signed [ShiftW-1:0] sx;
    logic signed [ShiftW-1:0] sy;
    logic signed [ShiftW-1:0] sz;
  } cordic_slot_t;

  function automatic logic signed [LaneW-1:0] atan_units(input logic [StepW-1:0] idx);
    logic signed [LaneW-1:0] v;
    case (idx)
      4'd0:    v = 34'sh020000000;
      4'd1:    v = 34'sh012E4051E;
      4'd2:    v = 34'sh009FB385B;
      4'd3:    v = 34'sh0051111D4;
      4'd4:    v = 34'sh0028B0D43;
      4'd5:    v = 34'sh00145D7E1;
      4'd6:    v = 34'sh000A2F61E;
      4'd7:    v = 34'sh000517C55;
      4'd8:    v = 34'sh00028BE53;
      4'd9:    v = 34'sh000145F2F;
      4'd10:   v = 34'sh0000A2F98;
      4'd11:   v = 34'sh0000517CC;
      4'd12:   v = 34'sh000028BE6;
      4'd13:   v = 34'sh0000145F3;
      4'd14:   v = 34'sh00000A2FA;
      default: v = 34'sh00000517D;
    endcase
    return v;
  endfunction

  // Q2.30 product, rounded half toward plus infinity
  function automatic logic signed [TrigW-1:0] mul_q30(input logic signed [TrigW-1:0] a,
                                                      input logic signed [TrigW-1:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return p[61:30];
  endfunction

  // Q2.30 to Q1.14 with rounding and saturation to plus or minus one
  function automatic logic signed [EntryW-1:0] to_q14(input logic signed [TrigW:0] v);
    logic signed [TrigW+1:0] t;
    logic signed [17:0]      r;
    t = 34'(v) + 34'sd32768;
    r = t[33:16];
    if (r > Q14One)       r = Q14One;
    else if (r < -Q14One) r = -Q14One;
    return r[EntryW-1:0];
  endfunction

endpackage

[sv/euler_pose_to_transform_core.sv]
// Top level: angle fold, chain of 16 CORDIC cells, matrix product pipeline.
// Depends on eptt_pkg, eptt_cordic_cell, eptt_matrix.
//
// Usage:
//   A pose request (roll, pitch, yaw binary angles and x, y, z Q16.16 shifts)
//   is taken on in_req at any rising edge where start is high and busy is low.
//   busy stays low: the pipeline takes one request every cycle.
//   Each request yields one result: nine Q1.14 rotation entries of
//   R = Rz(yaw)*Ry(pitch)*Rx(roll) and the translation passed through.
//   The result shows on out_res for one cycle with out_valid high,
//   after the request has passed through 1 fold stage, 16 CORDIC cells
//   (one iteration each, all three angles in parallel) and 3 matrix stages
//   (pairwise products, triple products, sums with saturation).
//   Throughput is one result per cycle, set by the fully pipelined cell chain.
//   Results in flight keep moving; the receiver has no way to stall them.
//   Reset clears the valid bits of every stage, so requests in flight are
//   dropped and no result appears until a new request has run through.
module euler_pose_to_transform_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  eptt_pkg::pose_req_t  in_req,
  output logic                 out_valid,
  output eptt_pkg::xform_res_t out_res
);

  eptt_pkg::cordic_slot_t chain [eptt_pkg::CordicSteps+1];
  eptt_pkg::cordic_slot_t fold_r, fold_nxt;
  logic signed [eptt_pkg::AngleW-1:0] ang [3];

  assign busy = 1'b0;

  assign ang[eptt_pkg::LROLL]  = in_req.roll_angle;
  assign ang[eptt_pkg::LPITCH] = in_req.pitch_angle;
  assign ang[eptt_pkg::LYAW]   = in_req.yaw_angle;

  // fold each angle into [-pi/2, pi/2]; negate sine and cosine afterwards
  always_comb begin
    fold_nxt.valid = start;
    fold_nxt.sx    = in_req.shift_x;
    fold_nxt.sy    = in_req.shift_y;
    fold_nxt.sz    = in_req.shift_z;
    for (int l = 0; l < 3; l++) begin
      logic signed [17:0] a;
      a = 18'(ang[l]);
      fold_nxt.lane[l].flip = 1'b0;
      if (a > eptt_pkg::QuarterTurn) begin
        a = a - eptt_pkg::HalfTurn;
        fold_nxt.lane[l].flip = 1'b1;
      end else if (a < -eptt_pkg::QuarterTurn) begin
        a = a + eptt_pkg::HalfTurn;
        fold_nxt.lane[l].flip = 1'b1;
      end
      fold_nxt.lane[l].x = eptt_pkg::CordicGain;
      fold_nxt.lane[l].y = '0;
      fold_nxt.lane[l].z = eptt_pkg::LaneW'(a) <<< 16;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fold_r <= '0;
    else        fold_r <= fold_nxt;
  end

  assign chain[0] = fold_r;

  for (genvar i = 0; i < eptt_pkg::CordicSteps; i++) begin : g_cell
    eptt_cordic_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .step_idx (eptt_pkg::StepW'(i)),
      .slot_in  (chain[i]),
      .slot_out (chain[i+1])
    );
  end

  eptt_matrix u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .slot_in   (chain[eptt_pkg::CordicSteps]),
    .res_valid (out_valid),
    .res       (out_res)
  );

endmodule

[sv/eptt_cordic_cell.sv]
// One rotation-mode CORDIC step applied to the three angle lanes of a chain slot.
// Depends on eptt_pkg.
module eptt_cordic_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [eptt_pkg::StepW-1:0] step_idx,
  input  eptt_pkg::cordic_slot_t     slot_in,
  output eptt_pkg::cordic_slot_t     slot_out
);

  eptt_pkg::cordic_slot_t slot_r, slot_nxt;
  logic signed [eptt_pkg::LaneW-1:0] atan_v;

  assign atan_v = eptt_pkg::atan_units(step_idx);

  always_comb begin
    slot_nxt = slot_in;
    for (int l = 0; l < 3; l++) begin
      if (!slot_in.lane[l].z[eptt_pkg::LaneW-1]) begin
        slot_nxt.lane[l].x = slot_in.lane[l].x - (slot_in.lane[l].y >>> step_idx);
        slot_nxt.lane[l].y = slot_in.lane[l].y + (slot_in.lane[l].x >>> step_idx);
        slot_nxt.lane[l].z = slot_in.lane[l].z - atan_v;
      end else begin
        slot_nxt.lane[l].x = slot_in.lane[l].x + (slot_in.lane[l].y >>> step_idx);
        slot_nxt.lane[l].y = slot_in.lane[l].y - (slot_in.lane[l].x >>> step_idx);
        slot_nxt.lane[l].z = slot_in.lane[l].z + atan_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) slot_r <= '0;
    else        slot_r <= slot_nxt;
  end

  assign slot_out = slot_r;

endmodule

[sv/eptt_matrix.sv]
// Three-stage product and sum pipeline forming R = Rz*Ry*Rx from sines and cosines.
// Depends on eptt_pkg.
module eptt_matrix (
  input  logic                   clk,
  input  logic                   rst_n,
  input  eptt_pkg::cordic_slot_t slot_in,
  output logic                   res_valid,
  output eptt_pkg::xform_res_t   res
);

  localparam int W = eptt_pkg::TrigW;

  logic signed [W-1:0] s_v [3];
  logic signed [W-1:0] c_v [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic signed [eptt_pkg::LaneW-1:0] xs, ys;
      xs = slot_in.lane[l].flip ? -slot_in.lane[l].x : slot_in.lane[l].x;
      ys = slot_in.lane[l].flip ? -slot_in.lane[l].y : slot_in.lane[l].y;
      c_v[l] = xs[W-1:0];
      s_v[l] = ys[W-1:0];
    end
  end

  // stage 1: pairwise products
  logic v1_r;
  logic signed [W-1:0] cysp_r, sysp_r, p00_r, p10_r, p21_r, p22_r;
  logic signed [W-1:0] q01_r, q02_r, q11_r, q12_r, sr1_r, cr1_r, sp1_r;
  logic signed [W-1:0] sx1_r, sy1_r, sz1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= slot_in.valid;
    cysp_r <= eptt_pkg::mul_q30(c_v[eptt_pkg::LYAW], s_v[eptt_pkg::LPITCH]);
    sysp_r <= eptt_pkg::mul_q30(s_v[eptt_pkg::LYAW], s_v[eptt_pkg::LPITCH]);
    p00_r  <= eptt_pkg::mul_q30(c_v[eptt_pkg::LYAW], c_v[eptt_pkg::LPITCH]);
    p10_r  <= eptt_pkg::mul_q30(s_v[eptt_pkg::LYAW], c_v[eptt_pkg::LPITCH]);
    p21_r  <= eptt_pkg::mul_q30(c_v[eptt_pkg::LPITCH], s_v[eptt_pkg::LROLL]);
    p22_r  <= eptt_pkg::mul_q30(c_v[eptt_pkg::LPITCH], c_v[eptt_pkg::LROLL]);
    q01_r  <= eptt_pkg::mul_q30(s_v[eptt_pkg::LYAW], c_v[eptt_pkg::LROLL]);
    q02_r  <= eptt_pkg::mul_q30(s_v[eptt_pkg::LYAW], s_v[eptt_pkg::LROLL]);
    q11_r  <= eptt_pkg::mul_q30(c_v[eptt_pkg::LYAW], c_v[eptt_pkg::LROLL]);
    q12_r  <= eptt_pkg::mul_q30(c_v[eptt_pkg::LYAW], s_v[eptt_pkg::LROLL]);
    sr1_r  <= s_v[eptt_pkg::LROLL];
    cr1_r  <= c_v[eptt_pkg::LROLL];
    sp1_r  <= s_v[eptt_pkg::LPITCH];
    sx1_r  <= slot_in.sx;
    sy1_r  <= slot_in.sy;
    sz1_r  <= slot_in.sz;
  end

  // stage 2: triple products
  logic v2_r;
  logic signed [W-1:0] t01_r, t02_r, t11_r, t12_r;
  logic signed [W-1:0] p00b_r, p10b_r, p21b_r, p22b_r, q01b_r, q02b_r, q11b_r, q12b_r, sp2_r;
  logic signed [W-1:0] sx2_r, sy2_r, sz2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    t01_r  <= eptt_pkg::mul_q30(cysp_r, sr1_r);
    t02_r  <= eptt_pkg::mul_q30(cysp_r, cr1_r);
    t11_r  <= eptt_pkg::mul_q30(sysp_r, sr1_r);
    t12_r  <= eptt_pkg::mul_q30(sysp_r, cr1_r);
    p00b_r <= p00_r;
    p10b_r <= p10_r;
    p21b_r <= p21_r;
    p22b_r <= p22_r;
    q01b_r <= q01_r;
    q02b_r <= q02_r;
    q11b_r <= q11_r;
    q12b_r <= q12_r;
    sp2_r  <= sp1_r;
    sx2_r  <= sx1_r;
    sy2_r  <= sy1_r;
    sz2_r  <= sz1_r;
  end

  // stage 3: sums, rounding, saturation
  logic v3_r;
  eptt_pkg::xform_res_t res_r, res_nxt;

  always_comb begin
    res_nxt.r00   = eptt_pkg::to_q14(33'(p00b_r));
    res_nxt.r01   = eptt_pkg::to_q14(33'(t01_r) - 33'(q01b_r));
    res_nxt.r02   = eptt_pkg::to_q14(33'(t02_r) + 33'(q02b_r));
    res_nxt.r10   = eptt_pkg::to_q14(33'(p10b_r));
    res_nxt.r11   = eptt_pkg::to_q14(33'(t11_r) + 33'(q11b_r));
    res_nxt.r12   = eptt_pkg::to_q14(33'(t12_r) - 33'(q12b_r));
    res_nxt.r20   = eptt_pkg::to_q14(-33'(sp2_r));
    res_nxt.r21   = eptt_pkg::to_q14(33'(p21b_r));
    res_nxt.r22   = eptt_pkg::to_q14(33'(p22b_r));
    res_nxt.out_x = sx2_r;
    res_nxt.out_y = sy2_r;
    res_nxt.out_z = sz2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    res_r <= res_nxt;
  end

  assign res_valid = v3_r;
  assign res       = res_r;

endmodule

[sv/eptt_checker.sv]
// Port-level checker for euler_pose_to_transform_core, bound to the top level.
// Depends on eptt_pkg.
module eptt_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input eptt_pkg::pose_req_t  in_req,
  input logic                 out_valid,
  input eptt_pkg::xform_res_t out_res
);

  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_req_to_res: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##20 out_valid)
    else $error("request produced no result");

  a_res_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 20))
    else $error("result without request");

  a_shift_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res.out_x == $past(in_req.shift_x, 20)
               && out_res.out_z == $past(in_req.shift_z, 20))
    else $error("translation mismatch");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res.r20 <= 16'sd16384 && out_res.r20 >= -16'sd16384)
    else $error("entry out of range");

endmodule

bind euler_pose_to_transform_core eptt_checker u_eptt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_res   (out_res)
);

[verif/euler_pose_to_transform_core_test.sv]
// Self-checking test of euler_pose_to_transform_core: random and corner poses,
// predicted rotation entries and translation compared field by field.
// Depends on eptt_pkg and the core RTL.
module euler_pose_to_transform_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomPoses = 1300;
  localparam int CycleLimit  = 400000;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  eptt_pkg::pose_req_t  in_req;
  logic                 out_valid;
  eptt_pkg::xform_res_t out_res;

  euler_pose_to_transform_core i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  eptt_pkg::pose_req_t  pending_poses[$];
  eptt_pkg::xform_res_t expected_xforms[$];
  int         fail_count = 0;
  bit         stim_done = 0;
  int         gap_left = 0;
  int         cycle_count = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  // fold to [-quarter, quarter], then 16 rotation-mode CORDIC iterations
  function automatic void trig_of_angle(input logic signed [15:0] ang,
                                        output longint s, output longint c);
    longint a, x, y, z, nx;
    bit flip;
    a = ang;
    flip = 0;
    x = 652032874;
    y = 0;
    if (a > 16384) begin
      a -= 32768; flip = 1;
    end else if (a < -16384) begin
      a += 32768; flip = 1;
    end
    z = a * 65536;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - floor_shr(y, i); y = y + floor_shr(x, i);
        z -= eptt_pkg::atan_units(4'(i));
      end else begin
        nx = x + floor_shr(y, i); y = y - floor_shr(x, i);
        z += eptt_pkg::atan_units(4'(i));
      end
      x = nx;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic longint prod_q30(longint a, longint b);
    return floor_shr(a * b + (longint'(1) << 29), 30);
  endfunction

  function automatic logic signed [15:0] entry_q14(longint v);
    longint r;
    r = floor_shr(v + 32768, 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return 16'(r);
  endfunction

  function automatic eptt_pkg::xform_res_t pose_to_xform(eptt_pkg::pose_req_t p);
    eptt_pkg::xform_res_t t;
    longint sr, cr, sp, cp, sy, cy, cysp, sysp;
    trig_of_angle(p.roll_angle, sr, cr);
    trig_of_angle(p.pitch_angle, sp, cp);
    trig_of_angle(p.yaw_angle, sy, cy);
    cysp = prod_q30(cy, sp);
    sysp = prod_q30(sy, sp);
    t.r00 = entry_q14(prod_q30(cy, cp));
    t.r01 = entry_q14(prod_q30(cysp, sr) - prod_q30(sy, cr));
    t.r02 = entry_q14(prod_q30(cysp, cr) + prod_q30(sy, sr));
    t.r10 = entry_q14(prod_q30(sy, cp));
    t.r11 = entry_q14(prod_q30(sysp, sr) + prod_q30(cy, cr));
    t.r12 = entry_q14(prod_q30(sysp, cr) - prod_q30(cy, sr));
    t.r20 = entry_q14(-sp);
    t.r21 = entry_q14(prod_q30(cp, sr));
    t.r22 = entry_q14(prod_q30(cp, cr));
    t.out_x = p.shift_x;
    t.out_y = p.shift_y;
    t.out_z = p.shift_z;
    return t;
  endfunction

  function automatic logic [15:0] pick_angle();
    logic [15:0] corners[10] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h4000,
                                 16'hc000, 16'h4001, 16'hbfff, 16'h3fff, 16'hc001};
    if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 9)];
    return 16'($urandom);
  endfunction

  initial begin
    eptt_pkg::pose_req_t p;
    logic [15:0] edge_angles[8] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff,
                                    16'h4000, 16'hc000, 16'h4001, 16'hbfff};
    // each angle at its corners, with extreme translations
    for (int i = 0; i < 8; i++) begin
      p.roll_angle = edge_angles[i];
      p.pitch_angle = edge_angles[(i + 3) % 8];
      p.yaw_angle = edge_angles[(i + 5) % 8];
      p.shift_x = i[0] ? 32'h8000_0000 : 32'h7fff_ffff;
      p.shift_y = i[1] ? 32'hffff_ffff : 32'h0000_0000;
      p.shift_z = i[2] ? 32'h0001_0000 : 32'h8000_0001;
      pending_poses.push_back(p);
    end
    for (int i = 0; i < 8; i++) begin
      p = '0;
      p.roll_angle = edge_angles[i];
      p.pitch_angle = edge_angles[i];
      p.yaw_angle = edge_angles[i];
      pending_poses.push_back(p);
    end
    for (int i = 0; i < RandomPoses; i++) begin
      p.roll_angle = pick_angle();
      p.pitch_angle = pick_angle();
      p.yaw_angle = pick_angle();
      p.shift_x = $urandom;
      p.shift_y = $urandom;
      p.shift_z = $urandom;
      pending_poses.push_back(p);
    end
    stim_done = 1;
  end

  // driver: one request per accepted edge, random gaps in between
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_xforms.push_back(pose_to_xform(in_req));
        void'(pending_poses.pop_front());
      end
      if (start && busy) begin
        // request still waiting, hold it
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_poses.size() > 0) begin
        start <= 1'b1;
        in_req <= pending_poses[0];
        if ($urandom_range(0, 3) == 0)
          gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                   : $urandom_range(1, 3);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    eptt_pkg::xform_res_t e;
    if (rst_n && out_valid) begin
      if (expected_xforms.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        e = expected_xforms.pop_front();
        if (out_res.r00 !== e.r00) begin
          $error("r00 exp %0d got %0d", e.r00, out_res.r00); fail_count++;
        end
        if (out_res.r01 !== e.r01) begin
          $error("r01 exp %0d got %0d", e.r01, out_res.r01); fail_count++;
        end
        if (out_res.r02 !== e.r02) begin
          $error("r02 exp %0d got %0d", e.r02, out_res.r02); fail_count++;
        end
        if (out_res.r10 !== e.r10) begin
          $error("r10 exp %0d got %0d", e.r10, out_res.r10); fail_count++;
        end
        if (out_res.r11 !== e.r11) begin
          $error("r11 exp %0d got %0d", e.r11, out_res.r11); fail_count++;
        end
        if (out_res.r12 !== e.r12) begin
          $error("r12 exp %0d got %0d", e.r12, out_res.r12); fail_count++;
        end
        if (out_res.r20 !== e.r20) begin
          $error("r20 exp %0d got %0d", e.r20, out_res.r20); fail_count++;
        end
        if (out_res.r21 !== e.r21) begin
          $error("r21 exp %0d got %0d", e.r21, out_res.r21); fail_count++;
        end
        if (out_res.r22 !== e.r22) begin
          $error("r22 exp %0d got %0d", e.r22, out_res.r22); fail_count++;
        end
        if (out_res.out_x !== e.out_x) begin
          $error("out_x exp %0d got %0d", e.out_x, out_res.out_x); fail_count++;
        end
        if (out_res.out_y !== e.out_y) begin
          $error("out_y exp %0d got %0d", e.out_y, out_res.out_y); fail_count++;
        end
        if (out_res.out_z !== e.out_z) begin
          $error("out_z exp %0d got %0d", e.out_z, out_res.out_z); fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout with %0d results outstanding", expected_xforms.size());
      $display("euler_pose_to_transform_core_test NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && pending_poses.size() == 0);
    @(posedge clk);
    while (start || expected_xforms.size() != 0) @(posedge clk);
    repeat (eptt_pkg::Latency + 5) @(posedge clk);
    if (fail_count == 0)
      $display("euler_pose_to_transform_core_test OK");
    else
      $display("euler_pose_to_transform_core_test NOT OK");
    $finish;
  end

endmodule

[files.f]
sv/eptt_pkg.sv
sv/eptt_cordic_cell.sv
sv/eptt_matrix.sv
sv/euler_pose_to_transform_core.sv
sv/eptt_checker.sv
verif/euler_pose_to_transform_core_test.sv
